FILE: hw/rtl/rirm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rirm_pkg: shared definitions for the range increment / range maximum block
// Default sizes, operation, status and register codes, and the command
// that the control logic sends to every point cell.
// ----------------------------------------------------------------------------
package rirm_pkg;

   localparam int DEF_POINTS     = 64;
   localparam int DEF_COUNT_BITS = 16;

   localparam int FIELD_BITS = 16;
   localparam int CSR_IDX_BITS = 2;

   // Operation codes carried by req_operation.
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Status codes carried by rsp_status.
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPAN_LOW  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPAN_HIGH = 2'd1;

   localparam logic [FIELD_BITS-1:0] SPAN_LOW_RESET  = 16'd0;
   localparam logic [FIELD_BITS-1:0] SPAN_HIGH_RESET = 16'd63;

   typedef struct packed {
      logic clear;   // drop every counter to zero
      logic incr;    // add one to counters inside the interval
   } cell_cmd_type;

endpackage

FILE: hw/rtl/rirm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rirm_cell: one point of the chain
// Holds the saturating counter of one point and passes a running maximum
// on to the next cell every cycle.
// ----------------------------------------------------------------------------
module rirm_cell
   import rirm_pkg::*;
#(
   parameter int IDX_BITS   = 6,
   parameter int COUNT_BITS = DEF_COUNT_BITS,
   parameter int INDEX      = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_cmd_type          cmd,
   input  logic [IDX_BITS-1:0]   lo_idx,
   input  logic [IDX_BITS-1:0]   hi_idx,
   input  logic [COUNT_BITS-1:0] max_in,
   output logic [COUNT_BITS-1:0] max_out
);

   localparam logic [IDX_BITS-1:0]   MY_IDX    = IDX_BITS'(INDEX);
   localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] max_ff, max_in_next;
   logic                  in_range;

   assign in_range = (MY_IDX >= lo_idx) && (MY_IDX <= hi_idx);

   always_comb begin
      count_in = count_ff;
      if (cmd.clear) begin
         count_in = '0;
      end else if (cmd.incr && in_range && (count_ff != COUNT_TOP)) begin
         count_in = count_ff + COUNT_BITS'(1);
      end
   end

   always_comb begin
      max_in_next = max_in;
      if (in_range && (count_ff > max_in)) begin
         max_in_next = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      max_ff <= max_in_next;
   end

   assign max_out = max_ff;

endmodule

FILE: hw/rtl/range_increment_range_max.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_increment_range_max: interval counter with range add and range max
// Keeps one saturating counter per point of a configured span and answers
// interval add and interval maximum commands.
// ----------------------------------------------------------------------------
// Usage:
//   A command is transferred at a clock edge where start is high and busy is
//   low. req_operation selects an add of one over [req_range_start,
//   req_range_end] or a query of the largest count over that interval.
//   Exactly one result follows on rsp_max_count and rsp_status, shown for a
//   single cycle with rsp_strobe high; the receiver cannot stall it.
//   An add, and any command with a bad interval, answers through the
//   ST_UPDATE state. A query waits in ST_QUERY while the running maximum
//   moves one cell per cycle down the chain of POINTS point cells, then
//   answers. A new command can be transferred in the cycle the result shows.
//   The user must write the span registers through csr_we, csr_index and
//   csr_wdata only while idle; the block itself does not enforce this. Each
//   write of a span register clears every counter in that cycle. Reset clears
//   all counters and loads the default span at once, with no clearing pass.
// ----------------------------------------------------------------------------
module range_increment_range_max
   import rirm_pkg::*;
#(
   parameter int POINTS     = DEF_POINTS,
   parameter int COUNT_BITS = DEF_COUNT_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_operation,
   input  logic [FIELD_BITS-1:0]   req_range_start,
   input  logic [FIELD_BITS-1:0]   req_range_end,
   output logic                    rsp_strobe,
   output logic [FIELD_BITS-1:0]   rsp_max_count,
   output logic                    rsp_status,
   input  logic                    csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [FIELD_BITS-1:0]   csr_wdata
);

   localparam int IDX_BITS = (POINTS > 1) ? $clog2(POINTS) : 1;
   localparam int CNT_BITS = $clog2(POINTS + 1);
   localparam int CMP_BITS = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS;
   localparam int WIDE_BITS = FIELD_BITS + 1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_UPDATE = 3'b010,
      ST_QUERY  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [FIELD_BITS-1:0] span_low_ff, span_low_in;
   logic [FIELD_BITS-1:0] span_high_ff, span_high_in;
   logic [IDX_BITS-1:0]   lo_ff, lo_in;
   logic [IDX_BITS-1:0]   hi_ff, hi_in;
   logic                  op_ff, op_in;
   logic                  ok_ff, ok_in;
   logic [CNT_BITS-1:0]   step_ff, step_in;
   logic                  strobe_ff, strobe_in;
   logic [FIELD_BITS-1:0] max_ff, max_in;
   logic                  status_ff, status_in;

   logic                  accept;
   logic                  csr_hit;
   logic [WIDE_BITS-1:0]  eff_top;
   logic [WIDE_BITS-1:0]  eff_high;
   logic                  req_ok;
   logic [CMP_BITS-1:0]   chain_ext;
   logic [FIELD_BITS-1:0] chain_sat;
   cell_cmd_type          cmd;

   logic [COUNT_BITS-1:0] chain [POINTS+1];

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff != ST_IDLE);
   assign csr_hit = csr_we && ((csr_index == CSR_SPAN_LOW) || (csr_index == CSR_SPAN_HIGH));

   // The usable span stops at the last stored point even if span_high is larger.
   assign eff_top  = {1'b0, span_low_ff} + WIDE_BITS'(POINTS - 1);
   assign eff_high = ({1'b0, span_high_ff} < eff_top) ? {1'b0, span_high_ff} : eff_top;

   assign req_ok = (span_high_ff >= span_low_ff)
                && (req_range_start <= req_range_end)
                && (req_range_start >= span_low_ff)
                && ({1'b0, req_range_end} <= eff_high);

   assign cmd.clear = csr_hit;
   assign cmd.incr  = (state_ff == ST_UPDATE) && ok_ff && (op_ff == OP_ADD);

   assign chain[0] = '0;

   for (genvar g = 0; g < POINTS; g++) begin : g_cell
      rirm_cell #(
         .IDX_BITS   (IDX_BITS),
         .COUNT_BITS (COUNT_BITS),
         .INDEX      (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .cmd     (cmd),
         .lo_idx  (lo_ff),
         .hi_idx  (hi_ff),
         .max_in  (chain[g]),
         .max_out (chain[g+1])
      );
   end

   assign chain_ext = CMP_BITS'(chain[POINTS]);
   assign chain_sat = (chain_ext > CMP_BITS'({FIELD_BITS{1'b1}})) ?
                      {FIELD_BITS{1'b1}} : chain_ext[FIELD_BITS-1:0];

   always_comb begin
      span_low_in  = span_low_ff;
      span_high_in = span_high_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SPAN_LOW:  span_low_in  = csr_wdata;
            CSR_SPAN_HIGH: span_high_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      op_in     = op_ff;
      ok_in     = ok_ff;
      step_in   = step_ff;
      strobe_in = 1'b0;
      max_in    = max_ff;
      status_in = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               lo_in   = IDX_BITS'(req_range_start - span_low_ff);
               hi_in   = IDX_BITS'(req_range_end - span_low_ff);
               op_in   = req_operation;
               ok_in   = req_ok;
               step_in = '0;
               if (req_ok && (req_operation == OP_QUERY)) begin
                  state_in = ST_QUERY;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            strobe_in = 1'b1;
            max_in    = '0;
            status_in = ok_ff ? STATUS_OK : STATUS_ERR;
            state_in  = ST_IDLE;
         end
         ST_QUERY: begin
            // The last cell holds the full maximum once every stage has refilled.
            if (step_ff == CNT_BITS'(POINTS)) begin
               strobe_in = 1'b1;
               max_in    = chain_sat;
               status_in = STATUS_OK;
               state_in  = ST_IDLE;
            end else begin
               step_in = step_ff + CNT_BITS'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         span_low_ff  <= SPAN_LOW_RESET;
         span_high_ff <= SPAN_HIGH_RESET;
         strobe_ff    <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         span_low_ff  <= span_low_in;
         span_high_ff <= span_high_in;
         strobe_ff    <= strobe_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      op_ff     <= op_in;
      ok_ff     <= ok_in;
      max_ff    <= max_in;
      status_ff <= status_in;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_max_count = max_ff;
   assign rsp_status    = status_ff;

endmodule
